FILE: rtl/greedy_budget_grid_selector_core_macros.svh
// Assertion macros used by the datapath RTL file.
`ifndef GREEDY_BUDGET_GRID_SELECTOR_CORE_MACROS_SVH
`define GREEDY_BUDGET_GRID_SELECTOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define GBGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define GBGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define GBGS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GBGS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/gbgs_pkg.sv
`default_nettype none
package gbgs_pkg;

    localparam int REWARD_W    = 16;
    localparam int TOTAL_W     = 26;
    localparam int BUDGET_W    = 20;
    localparam int ROW_CNT_W   = 4;
    localparam int COL_CNT_W   = 4;
    localparam int DEPTH_CNT_W = 5;
    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_MAX_DEPTH   = 16;
    localparam int DEF_REWARD_BITS = 16;

    localparam logic [TOTAL_W-1:0]     TOTAL_MAX       = '1;
    localparam logic [ROW_CNT_W-1:0]   ROW_CNT_RESET   = 4'd8;
    localparam logic [COL_CNT_W-1:0]   COL_CNT_RESET   = 4'd8;
    localparam logic [DEPTH_CNT_W-1:0] DEPTH_CNT_RESET = 5'd16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_COUNT    = 8'd0,
        CFG_COL_COUNT    = 8'd1,
        CFG_DEPTH_COUNT  = 8'd2,
        CFG_START_BUDGET = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [REWARD_W-1:0] reward;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total_reward;
        logic [BUDGET_W-1:0] total_cost;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic sel_init;
        logic scan_init;
        logic total_clear;
        logic k_from_reach;
        logic k_zero;
        logic k_inc;
        logic cell_next;
        logic cand_cmp;
        logic commit;
        logic budget_clear;
        logic sum_add;
        logic out_load;
        logic clear_step;
    } dp_cmd_t;

    typedef struct packed {
        logic k_end;
        logic k_past;
        logic cell_last;
        logic found;
        logic budget_zero;
        logic out_busy;
        logic clear_last;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/gbgs_datapath.sv
`default_nettype none
`include "greedy_budget_grid_selector_core_macros.svh"
module gbgs_datapath
    import gbgs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int REWARD_BITS = DEF_REWARD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CELLS      = MAX_ROWS * MAX_COLS;
    localparam int STORE_SIZE = CELLS * MAX_DEPTH;
    localparam int AW   = $clog2(STORE_SIZE);
    localparam int CIW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CJW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW   = $clog2(MAX_DEPTH);
    localparam int KW   = $clog2(MAX_DEPTH + 1);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int COST_MAX = 2 * ((MAX_ROWS - 1) + (MAX_COLS - 1) + (MAX_DEPTH - 1));
    localparam int CW   = $clog2(COST_MAX + 1);
    localparam int PW   = REWARD_BITS + CW;
    localparam int SW   = TOTAL_W + REWARD_BITS + 1;

    logic [REWARD_BITS-1:0] reward_mem [STORE_SIZE];
    logic [DW-1:0]          depth_mem  [CELLS];
    logic [CJW-1:0]         col_mem    [MAX_ROWS];

    logic [ROW_CNT_W-1:0]   row_cnt_reg;
    logic [COL_CNT_W-1:0]   col_cnt_reg;
    logic [DEPTH_CNT_W-1:0] depth_cnt_reg;
    logic [BUDGET_W-1:0]    start_budget_reg;

    logic [RCW-1:0]         rc_reg;
    logic [CCW-1:0]         cc_reg;
    logic [KW-1:0]          dc_reg;
    logic [AW-1:0]          load_ptr_reg;
    logic [CIW-1:0]         clr_idx_reg;
    logic [RIW-1:0]         i_reg;
    logic [CJW-1:0]         j_reg;
    logic [KW-1:0]          k_reg;
    logic [AW-1:0]          base_reg;
    logic [RIW-1:0]         row_reach_reg;
    logic [BUDGET_W-1:0]    budget_reg;
    logic [BUDGET_W-1:0]    cost_sum_reg;
    logic [DW-1:0]          dr_q;
    logic [CJW-1:0]         cr_q;
    logic [REWARD_BITS-1:0] rew_q;
    logic [CW-1:0]          cand_cost_reg;
    logic                   feas_reg;
    logic [PW-1:0]          prod_a_reg;
    logic [PW-1:0]          prod_b_reg;
    logic                   found_reg;
    logic [REWARD_BITS-1:0] best_rew_reg;
    logic [CW-1:0]          lead_cost_reg;
    logic [RIW-1:0]         bi_reg;
    logic [CJW-1:0]         bj_reg;
    logic [KW-1:0]          bk_reg;
    logic [CJW-1:0]         best_cr_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [CIW-1:0]         cell_rd;
    logic [CIW-1:0]         cell_best;
    logic [AW-1:0]          rew_addr;
    logic [RIW-1:0]         gi;
    logic [CJW-1:0]         gj;
    logic [CW-1:0]          cand_cost_next;
    logic [SW-1:0]          sum_w;
    logic                   j_last;

    always_comb begin
        cell_rd   = CIW'(32'(i_reg) * MAX_COLS + 32'(j_reg));
        cell_best = CIW'(32'(bi_reg) * MAX_COLS + 32'(bj_reg));
        rew_addr  = AW'(32'(base_reg) + 32'(k_reg));
        gi = (i_reg > row_reach_reg) ? RIW'(i_reg - row_reach_reg) : '0;
        gj = (j_reg > cr_q) ? CJW'(j_reg - cr_q) : '0;
        cand_cost_next = CW'((32'(gi) + 32'(gj) + 32'(k_reg) - 32'(dr_q)) << 1);
        sum_w  = SW'(total_reg) + SW'(rew_q);
        j_last = (32'(j_reg) == 32'(cc_reg) - 1);
    end

    always_comb begin
        sts.k_end       = (32'(k_reg) >= 32'(dc_reg));
        sts.k_past      = (32'(k_reg) > 32'(dr_q));
        sts.cell_last   = j_last && (32'(i_reg) == 32'(rc_reg) - 1);
        sts.found       = found_reg;
        sts.budget_zero = (budget_reg == '0);
        sts.out_busy    = out_valid_reg;
        sts.clear_last  = (32'(clr_idx_reg) == CELLS - 1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            reward_mem[load_ptr_reg] <= REWARD_BITS'(s_data.reward);
        end
        rew_q <= reward_mem[rew_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            depth_mem[clr_idx_reg] <= '0;
        end else if (cmd.commit) begin
            depth_mem[cell_best] <= DW'(bk_reg);
        end
        dr_q <= depth_mem[cell_rd];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step && (32'(clr_idx_reg) < MAX_ROWS)) begin
            col_mem[RIW'(clr_idx_reg)] <= '0;
        end else if (cmd.commit && (bj_reg > best_cr_reg)) begin
            col_mem[bi_reg] <= bj_reg;
        end
        cr_q <= col_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        cand_cost_reg <= cand_cost_next;
        feas_reg      <= (32'(cand_cost_reg) <= 32'(budget_reg));
        prod_a_reg    <= PW'(rew_q) * PW'(lead_cost_reg);
        prod_b_reg    <= PW'(best_rew_reg) * PW'(cand_cost_reg);
        if (cmd.cand_cmp && feas_reg && (!found_reg || prod_a_reg > prod_b_reg)) begin
            best_rew_reg  <= rew_q;
            lead_cost_reg <= cand_cost_reg;
            bi_reg        <= i_reg;
            bj_reg        <= j_reg;
            bk_reg        <= k_reg;
            best_cr_reg   <= cr_q;
        end
        if (cmd.total_clear) begin
            total_reg <= '0;
        end else if (cmd.sum_add) begin
            total_reg <= (sum_w > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_w);
        end
        if (cmd.out_load) begin
            out_data_reg.total_reward <= total_reg;
            out_data_reg.total_cost   <= cost_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg      <= ROW_CNT_RESET;
            col_cnt_reg      <= COL_CNT_RESET;
            depth_cnt_reg    <= DEPTH_CNT_RESET;
            start_budget_reg <= '0;
            load_ptr_reg     <= '0;
            clr_idx_reg      <= '0;
            budget_reg       <= '0;
            cost_sum_reg     <= '0;
            row_reach_reg    <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            rc_reg           <= '0;
            cc_reg           <= '0;
            dc_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            base_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_ROW_COUNT:    row_cnt_reg      <= cfg_wdata[ROW_CNT_W-1:0];
                    CFG_COL_COUNT:    col_cnt_reg      <= cfg_wdata[COL_CNT_W-1:0];
                    CFG_DEPTH_COUNT:  depth_cnt_reg    <= cfg_wdata[DEPTH_CNT_W-1:0];
                    CFG_START_BUDGET: start_budget_reg <= cfg_wdata[BUDGET_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                if (s_data.last || (32'(load_ptr_reg) == STORE_SIZE - 1)) begin
                    load_ptr_reg <= '0;
                end else begin
                    load_ptr_reg <= AW'(32'(load_ptr_reg) + 1);
                end
            end
            if (cmd.clear_step) begin
                clr_idx_reg <= sts.clear_last ? '0 : CIW'(32'(clr_idx_reg) + 1);
            end
            if (cmd.sel_init) begin
                budget_reg    <= start_budget_reg;
                cost_sum_reg  <= '0;
                row_reach_reg <= '0;
                rc_reg <= (row_cnt_reg == '0) ? RCW'(1) :
                          (32'(row_cnt_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(row_cnt_reg);
                cc_reg <= (col_cnt_reg == '0) ? CCW'(1) :
                          (32'(col_cnt_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(col_cnt_reg);
                dc_reg <= (depth_cnt_reg == '0) ? KW'(1) :
                          (32'(depth_cnt_reg) > MAX_DEPTH) ? KW'(MAX_DEPTH) :
                          KW'(depth_cnt_reg);
            end
            if (cmd.budget_clear) begin
                budget_reg <= '0;
            end else if (cmd.commit) begin
                budget_reg   <= budget_reg - BUDGET_W'(lead_cost_reg);
                cost_sum_reg <= cost_sum_reg + BUDGET_W'(lead_cost_reg);
                if (bi_reg > row_reach_reg) begin
                    row_reach_reg <= bi_reg;
                end
            end
            if (cmd.scan_init) begin
                i_reg     <= '0;
                j_reg     <= '0;
                base_reg  <= '0;
                found_reg <= 1'b0;
            end else if (cmd.cell_next) begin
                base_reg <= AW'(32'(base_reg) + 32'(dc_reg));
                if (j_last) begin
                    j_reg <= '0;
                    i_reg <= RIW'(32'(i_reg) + 1);
                end else begin
                    j_reg <= CJW'(32'(j_reg) + 1);
                end
            end else if (cmd.cand_cmp && feas_reg) begin
                found_reg <= 1'b1;
            end
            if (cmd.k_from_reach) begin
                k_reg <= KW'(32'(dr_q) + 1);
            end else if (cmd.k_zero) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= KW'(32'(k_reg) + 1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `GBGS_ASSERT_IMP(a_commit_found, aclk, aresetn, cmd.commit, found_reg)
    `GBGS_ASSERT_IMP(a_commit_fits, aclk, aresetn, cmd.commit, 32'(lead_cost_reg) <= 32'(budget_reg))
    `GBGS_ASSERT_IMP(a_out_free, aclk, aresetn, cmd.out_load, !out_valid_reg)
    `GBGS_ASSERT_NXT(a_ptr_rewind, aclk, aresetn, cmd.load && s_data.last, load_ptr_reg == '0)

endmodule
`default_nettype wire

FILE: rtl/gbgs_controller.sv
`default_nettype none
module gbgs_controller
    import gbgs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_last,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_SEL_INIT,
        ST_ROUND_CHK,
        ST_ROUND_INIT,
        ST_CELL_RD,
        ST_CELL_K,
        ST_CAND_CHK,
        ST_CAND_MUL,
        ST_CAND_CMP,
        ST_ROUND_END,
        ST_SUM_INIT,
        ST_SUM_RD,
        ST_SUM_K,
        ST_SUM_CHK,
        ST_SUM_ADD,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        state_next = ST_SEL_INIT;
                    end
                end
            end
            ST_SEL_INIT: begin
                cmd.sel_init = 1'b1;
                state_next   = ST_ROUND_CHK;
            end
            ST_ROUND_CHK: begin
                state_next = sts.budget_zero ? ST_SUM_INIT : ST_ROUND_INIT;
            end
            ST_ROUND_INIT: begin
                cmd.scan_init = 1'b1;
                state_next    = ST_CELL_RD;
            end
            ST_CELL_RD: begin
                state_next = ST_CELL_K;
            end
            ST_CELL_K: begin
                cmd.k_from_reach = 1'b1;
                state_next       = ST_CAND_CHK;
            end
            ST_CAND_CHK: begin
                if (!sts.k_end) begin
                    state_next = ST_CAND_MUL;
                end else if (sts.cell_last) begin
                    state_next = ST_ROUND_END;
                end else begin
                    cmd.cell_next = 1'b1;
                    state_next    = ST_CELL_RD;
                end
            end
            ST_CAND_MUL: begin
                state_next = ST_CAND_CMP;
            end
            ST_CAND_CMP: begin
                cmd.cand_cmp = 1'b1;
                cmd.k_inc    = 1'b1;
                state_next   = ST_CAND_CHK;
            end
            ST_ROUND_END: begin
                if (sts.found) begin
                    cmd.commit = 1'b1;
                    state_next = ST_ROUND_CHK;
                end else begin
                    cmd.budget_clear = 1'b1;
                    state_next       = ST_SUM_INIT;
                end
            end
            ST_SUM_INIT: begin
                cmd.scan_init   = 1'b1;
                cmd.total_clear = 1'b1;
                state_next      = ST_SUM_RD;
            end
            ST_SUM_RD: begin
                state_next = ST_SUM_K;
            end
            ST_SUM_K: begin
                cmd.k_zero = 1'b1;
                state_next = ST_SUM_CHK;
            end
            ST_SUM_CHK: begin
                if (!sts.k_past) begin
                    state_next = ST_SUM_ADD;
                end else if (sts.cell_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.cell_next = 1'b1;
                    state_next    = ST_SUM_RD;
                end
            end
            ST_SUM_ADD: begin
                cmd.sum_add = 1'b1;
                cmd.k_inc   = 1'b1;
                state_next  = ST_SUM_CHK;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/greedy_budget_grid_selector_core.sv
// Greedy budget grid selector.
// Input channel (s_valid/s_ready/s_data): one reward beat per cycle while
// loading, raster order row, column, depth; the beat with last set
// ends the grid and starts the selection. Config channel
// (cfg_valid/cfg_ready/cfg_addr/cfg_wdata) is always ready; write it only
// while the block is idle. Result channel (m_valid/m_ready/m_data): one
// beat per grid with the summed reward and the cost spent.
// After last, the search runs rounds; each round walks every cell of the
// grid in use and tries every depth past the cell's reached depth, one
// candidate at a time through the shared compare. The reward sum then adds
// the rewards of depth zero up to the reached depth of every cell.
// The result sits in an output register that a stalled receiver holds;
// the block waits only when its next result is ready and the old one
// is still held. After reset and after every result a clearing pass over
// MAX_ROWS*MAX_COLS cells zeroes the frontier; s_ready is low meanwhile.
`default_nettype none
module greedy_budget_grid_selector_core
    import gbgs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int REWARD_BITS = DEF_REWARD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    gbgs_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gbgs_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_DEPTH   (MAX_DEPTH),
        .REWARD_BITS (REWARD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire
